### rtl/core/golesc_pkg.sv
// ----------------------------------------------------------------------------
// Golomb escape encoder package
// Shared widths, the mode codes, the register indexes, the structs handed
// between the configuration stage, the divider cells and the top level,
// and a leading-one search used in more than one place.
// ----------------------------------------------------------------------------
package golesc_pkg;

  // Fixed field widths of the block.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VAL_W      = SAMPLE_W + 1;
  localparam int unsigned GP_W       = 16;
  localparam int unsigned LIM_W      = 17;
  localparam int unsigned K_W        = 4;
  localparam int unsigned OUTL_W     = 22;
  localparam int unsigned RLEN_W     = 5;
  localparam int unsigned CLEN_W     = 6;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // The quotient of a legal codeword never reaches 32, so five divider
  // cells cover every code length up to the largest codeword bound.
  localparam int unsigned QUOT_W = 5;
  localparam int unsigned DIV_W  = GP_W + QUOT_W - 1;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GPARAM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER = 2'd2;

  typedef enum logic [1:0] {
    MODE_RAW   = 2'd0,
    MODE_ZERO  = 2'd1,
    MODE_MULTI = 2'd2,
    MODE_BAD   = 2'd3
  } mode_e;

  // Configuration as seen by the sample path.
  typedef struct packed {
    mode_e              mode;
    logic [GP_W-1:0]    g;
    logic [K_W-1:0]     k;
    logic [VAL_W-1:0]   cutoff;
    logic [OUTL_W-1:0]  outl;
    logic               invalid;
  } derived_t;

  // Per-sample payload that rides along the divider chain.
  typedef struct packed {
    logic                short_code;
    logic [VAL_W-1:0]    v;
    logic [SAMPLE_W-1:0] raw;
    logic [RLEN_W-1:0]   rlen;
  } item_t;

  // Contents of one divider cell.
  typedef struct packed {
    item_t              item;
    logic [VAL_W-1:0]   rem;
    logic [QUOT_W-1:0]  quot;
    logic [DIV_W-1:0]   div;
  } cell_t;

  // Position of the highest set bit; zero for an input of zero or one.
  function automatic logic [K_W-1:0] msb_index(input logic [GP_W-1:0] x);
    logic [K_W-1:0] r;
    r = '0;
    for (int i = 0; i < GP_W; i++) begin
      if (x[i]) begin
        r = K_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/golomb_escape_sample_encoder.sv
// ----------------------------------------------------------------------------
// Golomb escape sample encoder
// Zigzag maps each signed sample and codes it with a Golomb code, with
// zero escape or multi escape for outliers, or passes it uncompressed.
// ----------------------------------------------------------------------------
// Usage:
//   Write encoder_mode, golomb_param and outlier_limit over the cfg channel
//   (index 0, 1, 2) while no sample is in flight. A write transfers when
//   cfg_valid_i and cfg_ready_o are both high.
//   A sample transfers on each rising edge with start high and busy low.
//   busy is high only during reset and the cycle after it, so one sample
//   can be taken every clock.
//   Each result is held for a single cycle with done_o high. The receiver
//   cannot stall the block. A sample passes through five delay stages that
//   give the derived configuration time to settle, the escape decision,
//   level and divider set-up stages, five divider cells with one quotient
//   bit each, and the output stage.
//   Reset returns the registers to uncompressed mode with divisor one and
//   limit zero, and empties the pipeline. Invalid configurations give a
//   result with status_o high and every other field zero.
// ----------------------------------------------------------------------------
module golomb_escape_sample_encoder
  import golesc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    sample_i,
  output logic                  done_o,
  output logic [CODE_W-1:0]     code_bits_o,
  output logic [CLEN_W-1:0]     code_length_o,
  output logic [SAMPLE_W-1:0]   raw_bits_o,
  output logic [RLEN_W-1:0]     raw_length_o,
  output logic                  status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned VW         = SAMPLE_BITS + 1;
  localparam int unsigned PRE_STAGES = 5;

  derived_t cfg;
  logic     acc;

  logic [PRE_STAGES-1:0]  pre_vld_q;
  logic [SAMPLE_BITS-1:0] pre_u_q [PRE_STAGES];

  logic [SAMPLE_BITS-1:0] u;
  logic [SAMPLE_BITS-1:0] mapped;
  logic                   esc;
  logic [SAMPLE_BITS-1:0] diff;
  logic [VW-1:0]          vbase;
  logic [SAMPLE_BITS-1:0] raw;

  logic                   e_vld_q;
  logic                   e_esc_q;
  logic [SAMPLE_BITS-1:0] e_diff_q;
  logic [VW-1:0]          e_vbase_q;
  logic [SAMPLE_BITS-1:0] e_raw_q;

  logic [K_W-1:0]         level;
  logic [VW-1:0]          v;
  logic [RLEN_W-1:0]      rlen;

  logic                   l_vld_q;
  logic [VW-1:0]          l_v_q;
  logic [SAMPLE_BITS-1:0] l_raw_q;
  logic [RLEN_W-1:0]      l_rlen_q;

  logic                   c_vld_q;
  cell_t                  c_cell_d;
  cell_t                  c_cell_q;

  logic [QUOT_W:0]        ch_vld;
  cell_t                  ch_cell [QUOT_W+1];
  cell_t                  fin;

  logic [CODE_W-1:0]      tail;
  logic [CODE_W-1:0]      unary;
  logic [CODE_W-1:0]      code_d;
  logic [CLEN_W-1:0]      clen_d;
  logic [SAMPLE_W-1:0]    raw_d;
  logic [RLEN_W-1:0]      rlen_d;
  logic                   status_d;

  logic                   done_q;
  logic [CODE_W-1:0]      code_q;
  logic [CLEN_W-1:0]      clen_q;
  logic [SAMPLE_W-1:0]    raw_q;
  logic [RLEN_W-1:0]      rlen_q;
  logic                   status_q;

  // Configuration registers and derived constants.
  golesc_cfg #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign busy = ~cfg_ready_o;
  assign acc  = start && !busy;

  // Sample delay line, which lets the derived configuration settle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
    end else begin
      pre_vld_q <= {pre_vld_q[PRE_STAGES-2:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    pre_u_q[0] <= sample_i[SAMPLE_BITS-1:0];
    for (int i = 1; i < PRE_STAGES; i++) begin
      pre_u_q[i] <= pre_u_q[i-1];
    end
  end

  // Zigzag mapping and the escape decision against the outlier.
  always_comb begin
    u      = pre_u_q[PRE_STAGES-1];
    mapped = {u[SAMPLE_BITS-2:0], 1'b0} ^ {SAMPLE_BITS{u[SAMPLE_BITS-1]}};
    esc    = OUTL_W'(mapped) >= cfg.outl;
    diff   = mapped - cfg.outl[SAMPLE_BITS-1:0];
    case (cfg.mode)
      MODE_RAW: begin
        vbase = VW'(mapped);
        raw   = u;
      end
      MODE_ZERO: begin
        vbase = esc ? '0 : VW'(mapped) + VW'(1);
        raw   = esc ? mapped : '0;
      end
      MODE_MULTI: begin
        vbase = esc ? cfg.outl[VW-1:0] : VW'(mapped);
        raw   = esc ? diff : '0;
      end
      default: begin
        vbase = VW'(mapped);
        raw   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= pre_vld_q[PRE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    e_esc_q   <= esc;
    e_diff_q  <= diff;
    e_vbase_q <= vbase;
    e_raw_q   <= raw;
  end

  // Escape level, the value to be coded and the raw bit count.
  always_comb begin
    level = msb_index(GP_W'(e_diff_q)) >> 1;
    v     = e_vbase_q;
    case (cfg.mode)
      MODE_RAW: begin
        rlen = RLEN_W'(SAMPLE_BITS);
      end
      MODE_ZERO: begin
        rlen = e_esc_q ? RLEN_W'(SAMPLE_BITS) : '0;
      end
      MODE_MULTI: begin
        if (e_esc_q) begin
          v    = e_vbase_q + VW'(level);
          rlen = RLEN_W'({level, 1'b0}) + RLEN_W'(2);
        end else begin
          rlen = '0;
        end
      end
      default: begin
        rlen = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_vld_q <= 1'b0;
    end else begin
      l_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l_v_q    <= v;
    l_raw_q  <= e_raw_q;
    l_rlen_q <= rlen;
  end

  // Short code test and divider set-up.
  always_comb begin
    c_cell_d.item.short_code = VAL_W'(l_v_q) < cfg.cutoff;
    c_cell_d.item.v          = VAL_W'(l_v_q);
    c_cell_d.item.raw        = SAMPLE_W'(l_raw_q);
    c_cell_d.item.rlen       = l_rlen_q;
    c_cell_d.rem             = VAL_W'(l_v_q) - cfg.cutoff;
    c_cell_d.quot            = '0;
    c_cell_d.div             = DIV_W'(cfg.g) << (QUOT_W - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= l_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_cell_q <= c_cell_d;
  end

  // Row of divider cells, most significant quotient bit first.
  assign ch_vld[0]  = c_vld_q;
  assign ch_cell[0] = c_cell_q;

  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    golesc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_vld[i]),
      .cell_i  (ch_cell[i]),
      .valid_o (ch_vld[i+1]),
      .cell_o  (ch_cell[i+1])
    );
  end

  assign fin = ch_cell[QUOT_W];

  // Codeword assembly: unary prefix over the truncated binary remainder.
  always_comb begin
    tail     = CODE_W'({fin.item.v - fin.item.v, 1'b0}) + CODE_W'({cfg.cutoff, 1'b0})
             + CODE_W'(fin.rem);
    unary    = (~({CODE_W{1'b1}} << fin.quot)) << (CLEN_W'(cfg.k) + CLEN_W'(2));
    code_d   = '0;
    clen_d   = '0;
    raw_d    = '0;
    rlen_d   = '0;
    status_d = 1'b0;
    if (cfg.invalid) begin
      status_d = 1'b1;
    end else if (cfg.mode == MODE_RAW) begin
      raw_d  = fin.item.raw;
      rlen_d = fin.item.rlen;
    end else begin
      raw_d  = fin.item.raw;
      rlen_d = fin.item.rlen;
      if (fin.item.short_code) begin
        code_d = CODE_W'(fin.item.v);
        clen_d = CLEN_W'(cfg.k) + CLEN_W'(1);
      end else begin
        code_d = unary + tail;
        clen_d = CLEN_W'(cfg.k) + CLEN_W'(2) + CLEN_W'(fin.quot);
      end
    end
  end

  // Output register; each result is shown for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ch_vld[QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    clen_q   <= clen_d;
    raw_q    <= raw_d;
    rlen_q   <= rlen_d;
    status_q <= status_d;
  end

  assign done_o        = done_q;
  assign code_bits_o   = code_q;
  assign code_length_o = clen_q;
  assign raw_bits_o    = raw_q;
  assign raw_length_o  = rlen_q;
  assign status_o      = status_q;

`ifndef ASSERT_OFF
  // Every accepted sample gives exactly one result, a fixed time later.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start && !busy, PRE_STAGES + 3 + QUOT_W + 1))
    else $error("result strobe does not match accepted samples");

  // An error result carries no code and no raw bits.
  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (code_bits_o == '0) && (code_length_o == '0)
                             && (raw_bits_o == '0) && (raw_length_o == '0))
    else $error("error result with non-empty fields");

  // Only an uncompressed result has no codeword, and it carries the sample.
  a_raw_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !status_o && (code_length_o == '0))
      |-> (raw_length_o == RLEN_W'(SAMPLE_BITS)))
    else $error("empty codeword without a full raw sample");
`endif

endmodule

### rtl/core/golesc_cfg.sv
// ----------------------------------------------------------------------------
// Golomb escape encoder configuration
// Holds the three configuration registers and works out the Golomb
// constants and the capped outlier over five register levels.
// ----------------------------------------------------------------------------
module golesc_cfg
  import golesc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output derived_t              cfg_o
);

  localparam int unsigned NK_W = $clog2(MAX_CODE_BITS);
  localparam int unsigned NESC = (SAMPLE_BITS + 1) / 2;

  logic              ready_q;
  mode_e             mode_q;
  logic [GP_W-1:0]   g_q;
  logic [LIM_W-1:0]  lim_q;

  logic [K_W-1:0]    k_q;
  logic [VAL_W-1:0]  cut_q;
  logic [NK_W-1:0]   nk_q;
  logic [OUTL_W-1:0] prod_q;
  logic [OUTL_W-1:0] oz_q;
  logic [OUTL_W-1:0] ubz_q;
  logic [OUTL_W-1:0] ubm_q;
  logic [OUTL_W-1:0] outl_q;
  logic [OUTL_W-1:0] lim_ext;

  // Register writes; ready is registered, so the port becomes ready on the clock edge after reset is released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      mode_q  <= MODE_RAW;
      g_q     <= GP_W'(1);
      lim_q   <= '0;
    end else begin
      ready_q <= 1'b1;
      if (cfg_valid_i && ready_q) begin
        case (cfg_index_i)
          REG_MODE:    mode_q <= mode_e'(cfg_data_i[1:0]);
          REG_GPARAM:  g_q    <= cfg_data_i[GP_W-1:0];
          REG_OUTLIER: lim_q  <= cfg_data_i[LIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign lim_ext = OUTL_W'(lim_q);

  // Derived constants. The levels run freely; the user must change the registers
  // only while no sample is in flight, which the block does not enforce, so that
  // each level has settled by the time a sample reaches the stage that reads it.
  always_ff @(posedge clk_i) begin
    k_q    <= msb_index(g_q);
    cut_q  <= (VAL_W'(2) << k_q) - VAL_W'(g_q);
    nk_q   <= NK_W'(MAX_CODE_BITS - 1) - NK_W'(k_q);
    prod_q <= OUTL_W'(nk_q) * OUTL_W'(g_q);
    oz_q   <= OUTL_W'(cut_q) + OUTL_W'(g_q) * OUTL_W'(SAMPLE_BITS) - OUTL_W'(1);
    ubz_q  <= OUTL_W'(cut_q) + prod_q;
    ubm_q  <= OUTL_W'(cut_q) + prod_q - OUTL_W'(NESC);
    if (mode_q == MODE_ZERO) begin
      outl_q <= (oz_q < ubz_q) ? oz_q : ubz_q;
    end else begin
      outl_q <= (lim_ext < ubm_q) ? lim_ext : ubm_q;
    end
  end

  // With a non-zero divisor the codeword bound is always positive, so the
  // outlier is zero only when the multi mode limit is zero.
  always_comb begin
    cfg_o.mode    = mode_q;
    cfg_o.g       = g_q;
    cfg_o.k       = k_q;
    cfg_o.cutoff  = cut_q;
    cfg_o.outl    = outl_q;
    cfg_o.invalid = (mode_q == MODE_BAD)
                 || ((mode_q != MODE_RAW) && (g_q == '0))
                 || ((mode_q == MODE_MULTI) && (lim_q == '0));
  end

  assign cfg_ready_o = ready_q;

endmodule

### rtl/core/golesc_div_cell.sv
// ----------------------------------------------------------------------------
// Golomb escape encoder divider cell
// One restoring division step: compares the partial remainder with the
// shifted divisor, shifts in one quotient bit and hands everything on.
// ----------------------------------------------------------------------------
module golesc_div_cell
  import golesc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  cell_t cell_i,
  output logic  valid_o,
  output cell_t cell_o
);

  logic  valid_q;
  cell_t cell_q;
  cell_t cell_d;
  logic  ge;

  // Trial subtraction and divisor shift for the next cell.
  always_comb begin
    cell_d = cell_i;
    ge     = DIV_W'(cell_i.rem) >= cell_i.div;
    if (ge) begin
      cell_d.rem = VAL_W'(DIV_W'(cell_i.rem) - cell_i.div);
    end
    cell_d.quot = {cell_i.quot[QUOT_W-2:0], ge};
    cell_d.div  = cell_i.div >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule
